// ===== rtl/core/mwtm_pkg.sv =====
// ============================================================================
// mwtm_pkg
// Shared types and constants for the mecanum wheel target mixer.
// ============================================================================
package mwtm_pkg;

    // Input item modes
    typedef enum logic [1:0] {
        MODE_SET  = 2'd0,
        MODE_STOP = 2'd1,
        MODE_FB   = 2'd2,
        MODE_TICK = 2'd3
    } mode_t;

    // Register indexes
    localparam logic [2:0] REG_MAX_TR   = 3'd0;
    localparam logic [2:0] REG_MAX_RO   = 3'd1;
    localparam logic [2:0] REG_CMD_TO   = 3'd2;
    localparam logic [2:0] REG_FB_TO    = 3'd3;
    localparam logic [2:0] REG_BST_SCL  = 3'd4;
    localparam logic [2:0] REG_BST_MIN  = 3'd5;
    localparam logic [2:0] REG_BST_DUR  = 3'd6;

    // Divider operand widths; the numerator holds |t| * ceiling for up to
    // 15 command fraction bits
    localparam int DIV_NUM_W = 61;
    localparam int DIV_DEN_W = 34;

    // Request and status between the sequencer and the divider
    typedef struct packed {
        logic                  start;
        logic [DIV_NUM_W-1:0]  num;
        logic [DIV_DEN_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIV_NUM_W-1:0]  quot;
    } div_sts_t;

endpackage

// ===== rtl/core/mecanum_wheel_target_mixer_core.sv =====
// ============================================================================
// mecanum_wheel_target_mixer_core
// Four-wheel mecanum target mixer with startup boost, timeouts and ceiling.
// ============================================================================
// Each item is latched and then executed in S_EXEC; a tick goes on through S_T_CHK
// and, unless the command is zero, S_T_BST, S_MIX and S_PEAK to S_OUT, with boost and
// ceiling divisions on the shared 61-step bit-serial divider (up to seven per tick).
// One item at a time; a finished tick waits until the previous result is taken.
// rst_n is asynchronous: FSM, held command, stamps, flags and configuration reset.
module mecanum_wheel_target_mixer_core
    import mwtm_pkg::*;
#(
    parameter int CMD_FRAC_BITS = 14,
    parameter int TIME_BITS     = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [15:0] forward_cmd,
    input  logic signed [15:0] strafe_cmd,
    input  logic signed [15:0] rotate_cmd,
    input  logic [31:0]        now_time,
    input  logic [2:0]         motor_index,
    input  logic               motor_present,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [18:0] wheel_target_1,
    output logic signed [18:0] wheel_target_2,
    output logic signed [18:0] wheel_target_3,
    output logic signed [18:0] wheel_target_4,
    output logic               drive_ok,
    output logic               command_idle,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int TW = TIME_BITS;
    localparam int CW = CMD_FRAC_BITS + 2;   // command magnitude incl sign
    localparam int TGW = CMD_FRAC_BITS + 17; // target width, signed
    localparam int SH = CMD_FRAC_BITS - 4;

    // ---------------- configuration ----------------
    logic [13:0] max_tr_reg, max_ro_reg;
    logic [15:0] cmd_to_reg, fb_to_reg, bst_dur_reg;
    logic [14:0] bst_scl_reg, bst_min_reg;
    logic        wr_en;
    logic [2:0]  wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign wr_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tr_reg  <= 14'd500;
            max_ro_reg  <= 14'd400;
            cmd_to_reg  <= 16'd300;
            fb_to_reg   <= 16'd250;
            bst_scl_reg <= 15'd12288;
            bst_min_reg <= 15'd3277;
            bst_dur_reg <= 16'd250;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_MAX_TR:  max_tr_reg  <= pwdata[13:0];
                REG_MAX_RO:  max_ro_reg  <= pwdata[13:0];
                REG_CMD_TO:  cmd_to_reg  <= pwdata[15:0];
                REG_FB_TO:   fb_to_reg   <= pwdata[15:0];
                REG_BST_SCL: bst_scl_reg <= pwdata[14:0];
                REG_BST_MIN: bst_min_reg <= pwdata[14:0];
                REG_BST_DUR: bst_dur_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            REG_MAX_TR:  prdata = {18'd0, max_tr_reg};
            REG_MAX_RO:  prdata = {18'd0, max_ro_reg};
            REG_CMD_TO:  prdata = {16'd0, cmd_to_reg};
            REG_FB_TO:   prdata = {16'd0, fb_to_reg};
            REG_BST_SCL: prdata = {17'd0, bst_scl_reg};
            REG_BST_MIN: prdata = {17'd0, bst_min_reg};
            REG_BST_DUR: prdata = {16'd0, bst_dur_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------- helpers ----------------
    function automatic logic signed [CW-1:0] clamp1(input logic signed [15:0] v);
        logic signed [16:0] one;
        logic signed [16:0] w;
        one = 17'sd1 <<< CMD_FRAC_BITS;
        w   = 17'(v);
        if (w > one)       clamp1 = CW'(one);
        else if (w < -one) clamp1 = CW'(-one);
        else               clamp1 = CW'(w);
    endfunction

    function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
        mag = v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    function automatic logic is_zero(input logic signed [CW-1:0] v);
        is_zero = ({14'd0, mag(v)} * 30'd10000) < (30'd1 << CMD_FRAC_BITS);
    endfunction

    function automatic logic [TW-1:0] elapsed(input logic [TW-1:0] a, input logic [TW-1:0] b);
        elapsed = (a >= b) ? a - b : '0;
    endfunction

    // ---------------- state ----------------
    logic signed [CW-1:0] hf_reg, hs_reg, hr_reg;
    logic [TW-1:0]        cstamp_reg, bstamp_reg;
    logic                 boost_reg;
    logic [3:0]           online_reg;
    logic [TW-1:0]        rstamp_reg [4];

    // Latched item
    logic [1:0]           mode_reg;
    logic signed [15:0]   if_reg, is_reg, ir_reg;
    logic [TW-1:0]        now_reg;
    logic [2:0]           idx_reg;
    logic                 pres_reg;

    // Working values
    logic signed [CW-1:0]  cv_reg [3];    // effective command
    logic signed [TGW-1:0] t_reg [4];
    logic [TGW-1:0]        peak_reg;
    logic [CW-1:0]         cpk_reg;
    logic [2:0]            k_reg;
    logic                  ok_reg, idle_reg;

    logic                  out_valid_reg;
    logic signed [18:0]    o_reg [4];
    logic                  o_ok_reg, o_idle_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_T_CHK, S_T_BST, S_BDIV, S_BWAIT,
        S_MIX, S_PEAK, S_CDIV, S_CWAIT, S_OUT
    } state_t;
    state_t state_reg;

    div_req_t dreq;
    div_sts_t dsts;

    mwtm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .sts(dsts));

    // online check over stored stamps
    logic all_on;
    always_comb
    begin
        all_on = 1'b1;
        for (int i = 0; i < 4; i++)
            if (!online_reg[i] || elapsed(now_reg, rstamp_reg[i]) > TW'(fb_to_reg))
                all_on = 1'b0;
    end

    // peak and zero flags of the held command and of the clamped new command
    logic [CW-1:0] hpk, npk;
    logic          hzero, nzero;
    logic signed [CW-1:0] nf, ns, nr;
    always_comb
    begin
        hpk = mag(hf_reg);
        if (mag(hs_reg) > hpk) hpk = mag(hs_reg);
        if (mag(hr_reg) > hpk) hpk = mag(hr_reg);
        hzero = is_zero(hf_reg) & is_zero(hs_reg) & is_zero(hr_reg);
        nf = clamp1(if_reg);
        ns = clamp1(is_reg);
        nr = clamp1(ir_reg);
        npk = mag(nf);
        if (mag(ns) > npk) npk = mag(ns);
        if (mag(nr) > npk) npk = mag(nr);
        nzero = is_zero(nf) & is_zero(ns) & is_zero(nr);
    end

    // divider operands
    logic [CW-1:0]  bmag;
    logic [TGW-1:0] tmag;
    logic [TGW-1:0] lim;
    logic [1:0]     k2;
    assign k2   = k_reg[1:0];
    assign bmag = mag(cv_reg[k2]);
    assign tmag = t_reg[k_reg[1:0]][TGW-1] ? TGW'(-t_reg[k2]) : TGW'(t_reg[k2]);
    assign lim  = TGW'({max_tr_reg, CMD_FRAC_BITS'(0)});

    // mix products, one multiply each cycle through the shared path
    logic signed [TGW-1:0] prod;
    logic signed [CW-1:0]  mcv;
    logic signed [15:0]    mgain;
    always_comb
    begin
        mcv   = cv_reg[k2];
        mgain = (k_reg == 3'd2) ? $signed({2'b00, max_ro_reg}) : $signed({2'b00, max_tr_reg});
        prod  = TGW'(mcv * mgain);
    end

    always_comb
    begin
        dreq = '0;
        if (state_reg == S_BDIV)
        begin
            dreq.start = 1'b1;
            dreq.num = DIV_NUM_W'(bmag * bst_scl_reg) + DIV_NUM_W'(cpk_reg >> 1);
            dreq.den = DIV_DEN_W'(cpk_reg);
        end
        else if (state_reg == S_CDIV)
        begin
            dreq.start = 1'b1;
            dreq.num = DIV_NUM_W'(tmag * lim) + DIV_NUM_W'(peak_reg >> 1);
            dreq.den = DIV_DEN_W'(peak_reg);
        end
    end

    // targets rounded to 4 fraction bits, halves away from zero
    logic [TGW-1:0]     rnd [4];
    logic signed [18:0] o_rnd [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rnd[i] = ((t_reg[i][TGW-1] ? TGW'(-t_reg[i]) : TGW'(t_reg[i]))
                      + (TGW'(1) << (SH - 1))) >> SH;
            o_rnd[i] = t_reg[i][TGW-1] ? 19'(-rnd[i]) : 19'(rnd[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hf_reg        <= '0;
            hs_reg        <= '0;
            hr_reg        <= '0;
            cstamp_reg    <= '0;
            bstamp_reg    <= '0;
            boost_reg     <= 1'b0;
            online_reg    <= '0;
            for (int i = 0; i < 4; i++) rstamp_reg[i] <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        mode_reg <= mode;
                        if_reg   <= forward_cmd;
                        is_reg   <= strafe_cmd;
                        ir_reg   <= rotate_cmd;
                        now_reg  <= TW'(now_time);
                        idx_reg  <= motor_index;
                        pres_reg <= motor_present;
                        state_reg <= S_EXEC;
                    end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    case (mode_t'(mode_reg))
                        MODE_SET:
                        begin
                            hf_reg <= nf;
                            hs_reg <= ns;
                            hr_reg <= nr;
                            cstamp_reg <= now_reg;
                            if (nzero)
                                boost_reg <= 1'b0;
                            else if (hzero && 32'(npk) >= 32'(bst_min_reg)
                                     && 32'(npk) < 32'(bst_scl_reg))
                            begin
                                bstamp_reg <= now_reg;
                                boost_reg  <= 1'b1;
                            end
                        end
                        MODE_STOP:
                        begin
                            cstamp_reg <= now_reg;
                            hf_reg <= '0;
                            hs_reg <= '0;
                            hr_reg <= '0;
                            boost_reg <= 1'b0;
                        end
                        MODE_FB:
                            if (idx_reg >= 3'd1 && idx_reg <= 3'd4)
                            begin
                                online_reg[idx_reg[1:0] - 2'd1] <= pres_reg;
                                rstamp_reg[idx_reg[1:0] - 2'd1] <= now_reg;
                            end
                        MODE_TICK:
                        begin
                            if (elapsed(now_reg, cstamp_reg) > TW'(cmd_to_reg))
                            begin
                                hf_reg <= '0;
                                hs_reg <= '0;
                                hr_reg <= '0;
                                boost_reg <= 1'b0;
                            end
                            state_reg <= S_T_CHK;
                        end
                        default: ;
                    endcase
                end
                S_T_CHK:
                begin
                    ok_reg   <= all_on;
                    cv_reg[0] <= hf_reg;
                    cv_reg[1] <= hs_reg;
                    cv_reg[2] <= hr_reg;
                    cpk_reg  <= hpk;
                    k_reg    <= '0;
                    for (int i = 0; i < 4; i++) t_reg[i] <= '0;
                    if (hzero)
                    begin
                        hf_reg <= '0;
                        hs_reg <= '0;
                        hr_reg <= '0;
                        boost_reg <= 1'b0;
                        idle_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idle_reg  <= 1'b0;
                        state_reg <= S_T_BST;
                    end
                end
                S_T_BST:
                begin
                    state_reg <= S_MIX;
                    if (boost_reg)
                    begin
                        if (elapsed(now_reg, bstamp_reg) >= TW'(bst_dur_reg))
                            boost_reg <= 1'b0;
                        else if (cpk_reg != '0 && 32'(cpk_reg) < 32'(bst_scl_reg))
                            state_reg <= S_BDIV;
                    end
                end
                S_BDIV:
                    state_reg <= S_BWAIT;
                S_BWAIT:
                    if (dsts.done)
                    begin
                        if (dsts.quot > DIV_NUM_W'(1 << CMD_FRAC_BITS))
                            cv_reg[k2] <= cv_reg[k2][CW-1] ? -(CW'(1) << CMD_FRAC_BITS)
                                                           : (CW'(1) << CMD_FRAC_BITS);
                        else
                            cv_reg[k2] <= cv_reg[k2][CW-1] ? CW'(-dsts.quot) : CW'(dsts.quot);
                        if (k_reg == 3'd2)
                        begin
                            k_reg <= '0;
                            state_reg <= S_MIX;
                        end
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                            state_reg <= S_BDIV;
                        end
                    end
                S_MIX:
                begin
                    // k=0: f=-cf*T, k=1: s, k=2: r; accumulate into targets
                    case (k_reg)
                        3'd0:
                        begin
                            t_reg[0] <= t_reg[0] + prod;
                            t_reg[1] <= t_reg[1] + prod;
                            t_reg[2] <= t_reg[2] - prod;
                            t_reg[3] <= t_reg[3] - prod;
                        end
                        3'd1:
                        begin
                            t_reg[0] <= t_reg[0] - prod;
                            t_reg[1] <= t_reg[1] + prod;
                            t_reg[2] <= t_reg[2] - prod;
                            t_reg[3] <= t_reg[3] + prod;
                        end
                        default:
                        begin
                            t_reg[0] <= t_reg[0] - prod;
                            t_reg[1] <= t_reg[1] - prod;
                            t_reg[2] <= t_reg[2] - prod;
                            t_reg[3] <= t_reg[3] - prod;
                        end
                    endcase
                    if (k_reg == 3'd2)
                    begin
                        k_reg    <= '0;
                        peak_reg <= '0;
                        state_reg <= S_PEAK;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_PEAK:
                begin
                    if (tmag > peak_reg) peak_reg <= tmag;
                    if (k_reg == 3'd3)
                    begin
                        k_reg <= '0;
                        if (((tmag > peak_reg) ? tmag : peak_reg) > lim)
                            state_reg <= S_CDIV;
                        else
                            state_reg <= S_OUT;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                S_CDIV:
                    state_reg <= S_CWAIT;
                S_CWAIT:
                    if (dsts.done)
                    begin
                        t_reg[k2] <= t_reg[k2][TGW-1] ? TGW'(-dsts.quot) : TGW'(dsts.quot);
                        if (k_reg == 3'd3)
                            state_reg <= S_OUT;
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                            state_reg <= S_CDIV;
                        end
                    end
                S_OUT:
                    if (!out_valid_reg || out_ready)
                    begin
                        for (int i = 0; i < 4; i++)
                            o_reg[i] <= (!ok_reg || idle_reg) ? '0 : o_rnd[i];
                        o_ok_reg      <= ok_reg;
                        o_idle_reg    <= idle_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // mix cycle uses sign: f = -cf*T is applied through the add pattern above
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign wheel_target_1 = o_reg[0];
    assign wheel_target_2 = o_reg[1];
    assign wheel_target_3 = o_reg[2];
    assign wheel_target_4 = o_reg[3];
    assign drive_ok       = o_ok_reg;
    assign command_idle   = o_idle_reg;

    // ---------------- assertions ----------------
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && command_idle) |-> (wheel_target_1 == 0 && wheel_target_4 == 0))
        else $error("idle tick with nonzero targets");
    a_nok_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !drive_ok) |-> (wheel_target_2 == 0 && wheel_target_3 == 0))
        else $error("drive not ok with nonzero targets");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !dsts.busy)
        else $error("divider busy while idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");

endmodule

// ===== rtl/core/mwtm_div.sv =====
// ============================================================================
// mwtm_div
// Restoring divider, one quotient bit per cycle; quotient rounded half up by
// the caller adding den/2 to the numerator.
// ============================================================================
module mwtm_div
    import mwtm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_sts_t sts
);

    localparam int CW = $clog2(DIV_NUM_W + 1);

    logic [DIV_NUM_W-1:0] quot_reg;
    logic [DIV_DEN_W:0]   rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W+1:0] diff;

    // Shift in next numerator bit and try subtract
    always_comb
    begin
        trial = {rem_reg[DIV_DEN_W-1:0], quot_reg[DIV_NUM_W-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                quot_reg <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
                cnt_reg  <= CW'(DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                if (diff[DIV_DEN_W+1])
                begin
                    rem_reg  <= trial;
                    quot_reg <= {quot_reg[DIV_NUM_W-2:0], 1'b0};
                end
                else
                begin
                    rem_reg  <= diff[DIV_DEN_W:0];
                    quot_reg <= {quot_reg[DIV_NUM_W-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sts.quot = quot_reg;

endmodule

// ===== verif/tb_mecanum_wheel_target_mixer_core.sv =====
// ============================================================================
// tb_mecanum_wheel_target_mixer_core
// Self-checking bench for the mecanum target mixer: a directed table, then
// random set/stop/feedback/tick traffic over several register settings, with each
// tick result compared against its table entry where given, else an in-bench model.
// ============================================================================
module tb_mecanum_wheel_target_mixer_core
    import mwtm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DRAIN_CYCLES = 400;
    localparam int  STALL_LIMIT  = 5000;
    localparam int  HOLD_CYCLES  = 600;
    localparam longint ONE_Q     = 64'sd16384;

    typedef struct packed {
        logic [18:0] tgt1;
        logic [18:0] tgt2;
        logic [18:0] tgt3;
        logic [18:0] tgt4;
        logic        ok;
        logic        idle;
    } wheel_res_t;

    typedef struct {
        mode_t              md;
        logic signed [15:0] fwd;
        logic signed [15:0] stf;
        logic signed [15:0] rot;
        logic [31:0]        now;
        logic [2:0]         idx;
        logic               pres;
        bit                 typed;
        wheel_res_t         res;
    } mix_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         mode = MODE_SET;
    logic signed [15:0] forward_cmd = '0;
    logic signed [15:0] strafe_cmd = '0;
    logic signed [15:0] rotate_cmd = '0;
    logic [31:0]        now_time = '0;
    logic [2:0]         motor_index = '0;
    logic               motor_present = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [18:0] wheel_target_1, wheel_target_2, wheel_target_3, wheel_target_4;
    logic               drive_ok, command_idle;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    mecanum_wheel_target_mixer_core dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mixer model state
    longint held_f, held_s, held_r;
    longint cmd_stamp, bst_stamp;
    bit     bst_on;
    bit     online[4];
    longint rep_stamp[4];
    longint regs[7];

    wheel_res_t exp_q[$];
    mix_item_t  dir_rows[$];
    int     n_err = 0;
    int     snd_pct = 0, rcv_pct = 0;
    int     hold_req = 0, hold_seen = 0, hold_cnt = 0;
    int     stall_cnt = 0;
    longint clock_ms = 0;

    function automatic longint clamp_unit(longint v);
        return v > ONE_Q ? ONE_Q : (v < -ONE_Q ? -ONE_Q : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint age(longint now, longint prev);
        return now >= prev ? now - prev : 0;
    endfunction

    function automatic bit near_zero(longint v);
        return mag(v) * 10000 < ONE_Q;
    endfunction

    function automatic bit cmd_is_zero();
        return near_zero(held_f) && near_zero(held_s) && near_zero(held_r);
    endfunction

    function automatic longint cmd_peak();
        longint p;
        p = mag(held_f);
        if (mag(held_s) > p) p = mag(held_s);
        if (mag(held_r) > p) p = mag(held_r);
        return p;
    endfunction

    // v*mul/den, nearest, halves away from zero
    function automatic longint ratio_round(longint v, longint mul, longint den);
        longint q;
        q = (mag(v) * mul + den / 2) / den;
        return v < 0 ? -q : q;
    endfunction

    function automatic logic [18:0] rpm_q4(longint v);
        longint q;
        q = (mag(v) + 512) >>> 10;
        return v < 0 ? 19'(-q) : 19'(q);
    endfunction

    function automatic bit motors_fresh(longint now);
        for (int i = 0; i < 4; i++)
            if (!online[i] || age(now, rep_stamp[i]) > regs[REG_FB_TO]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void stop_motion();
        held_f = 0;
        held_s = 0;
        held_r = 0;
        bst_on = 1'b0;
    endfunction

    function automatic void model_reset();
        regs = '{500, 400, 300, 250, 12288, 3277, 250};
        stop_motion();
        cmd_stamp = 0;
        bst_stamp = 0;
        for (int i = 0; i < 4; i++)
        begin
            online[i] = 1'b0;
            rep_stamp[i] = 0;
        end
    endfunction

    // Advance the model by one transfer; returns 1 when a result is due
    function automatic bit mix_predict(mix_item_t it, output wheel_res_t res);
        longint now, pk, cf, cs, cr, tr, f, s, r, lim, top;
        longint t[4];
        bit prev_zero, ok, idle;
        now = longint'(it.now);
        res = '0;
        case (it.md)
            MODE_SET:
            begin
                prev_zero = cmd_is_zero();
                held_f = clamp_unit(longint'(it.fwd));
                held_s = clamp_unit(longint'(it.stf));
                held_r = clamp_unit(longint'(it.rot));
                cmd_stamp = now;
                pk = cmd_peak();
                if (cmd_is_zero()) bst_on = 1'b0;
                else if (prev_zero && pk >= regs[REG_BST_MIN] && pk < regs[REG_BST_SCL])
                begin
                    bst_stamp = now;
                    bst_on = 1'b1;
                end
                return 1'b0;
            end
            MODE_STOP:
            begin
                cmd_stamp = now;
                stop_motion();
                return 1'b0;
            end
            MODE_FB:
            begin
                if (it.idx >= 1 && it.idx <= 4)
                begin
                    online[it.idx - 1] = it.pres;
                    rep_stamp[it.idx - 1] = now;
                end
                return 1'b0;
            end
            default: ;
        endcase
        t = '{0, 0, 0, 0};
        idle = 1'b0;
        if (age(now, cmd_stamp) > regs[REG_CMD_TO]) stop_motion();
        if (cmd_is_zero())
        begin
            stop_motion();
            idle = 1'b1;
            ok = motors_fresh(now);
        end
        else
        begin
            cf = held_f;
            cs = held_s;
            cr = held_r;
            pk = cmd_peak();
            if (bst_on)
            begin
                if (age(now, bst_stamp) >= regs[REG_BST_DUR]) bst_on = 1'b0;
                else if (pk > 0 && pk < regs[REG_BST_SCL])
                begin
                    cf = ratio_round(cf, regs[REG_BST_SCL], pk);
                    cs = ratio_round(cs, regs[REG_BST_SCL], pk);
                    cr = ratio_round(cr, regs[REG_BST_SCL], pk);
                end
            end
            tr = regs[REG_MAX_TR];
            f = -clamp_unit(cf) * tr;
            s = clamp_unit(cs) * tr;
            r = clamp_unit(cr) * regs[REG_MAX_RO];
            t[0] = -(f + s) - r;
            t[1] = -(f - s) - r;
            t[2] = (f - s) - r;
            t[3] = (f + s) - r;
            top = 0;
            for (int i = 0; i < 4; i++) if (mag(t[i]) > top) top = mag(t[i]);
            lim = tr <<< 14;
            if (top > lim && top > 0)
                for (int i = 0; i < 4; i++) t[i] = ratio_round(t[i], lim, top);
            ok = motors_fresh(now);
            if (!ok) t = '{0, 0, 0, 0};
        end
        res.tgt1 = rpm_q4(t[0]);
        res.tgt2 = rpm_q4(t[1]);
        res.tgt3 = rpm_q4(t[2]);
        res.tgt4 = rpm_q4(t[3]);
        res.ok   = ok;
        res.idle = idle;
        return 1'b1;
    endfunction

    // Stall watchdog, sampled mid-cycle: any transfer or register write resets the count
    always @(negedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result check, sampled mid-cycle ahead of the accepting edge
    always @(negedge clk)
    begin
        wheel_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_q.size() == 0)
            begin
                n_err++;
                $display("%0t unexpected result: %h %h %h %h ok=%b idle=%b", $time,
                         wheel_target_1, wheel_target_2, wheel_target_3, wheel_target_4,
                         drive_ok, command_idle);
            end
            else
            begin
                e = exp_q.pop_front();
                if (wheel_target_1 !== e.tgt1 || wheel_target_2 !== e.tgt2 ||
                    wheel_target_3 !== e.tgt3 || wheel_target_4 !== e.tgt4 ||
                    drive_ok !== e.ok || command_idle !== e.idle)
                begin
                    n_err++;
                    $display("%0t mismatch exp: %h %h %h %h ok=%b idle=%b", $time,
                             e.tgt1, e.tgt2, e.tgt3, e.tgt4, e.ok, e.idle);
                    $display("%0t          act: %h %h %h %h ok=%b idle=%b", $time,
                             wheel_target_1, wheel_target_2, wheel_target_3,
                             wheel_target_4, drive_ok, command_idle);
                end
            end
        end
    end

    // Result side: random back-pressure and long hold-off
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_cnt  <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rcv_pct);
        end
    end

    // Offer one transfer, wait for acceptance, then update the model
    task automatic send_item(mix_item_t it);
        wheel_res_t res;
        if (snd_pct > 0 && $urandom_range(0, 99) < snd_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= it.md;
        forward_cmd   <= it.fwd;
        strafe_cmd    <= it.stf;
        rotate_cmd    <= it.rot;
        now_time      <= it.now;
        motor_index   <= it.idx;
        motor_present <= it.pres;
        // ready is stable mid-cycle; the transfer happens at the next rising edge
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        if (mix_predict(it, res)) exp_q.push_back(it.typed ? it.res : res);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, longint val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        regs[idx] = val;
    endtask

    task automatic add_row(mode_t md, int f, int s, int r, int now, int idx, bit pres,
                           bit typed = 0, int t1 = 0, int t2 = 0, int t3 = 0, int t4 = 0,
                           bit ok = 0, bit idle = 0);
        mix_item_t it;
        it.md = md;
        it.fwd = 16'(f);
        it.stf = 16'(s);
        it.rot = 16'(r);
        it.now = 32'(now);
        it.idx = 3'(idx);
        it.pres = pres;
        it.typed = typed;
        it.res = '{19'(t1), 19'(t2), 19'(t3), 19'(t4), ok, idle};
        dir_rows.push_back(it);
    endtask

    function automatic logic signed [15:0] rand_cmd();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return 16'($urandom_range(0, 32768) - 16384);
        if (sel < 55) return 16'($urandom);
        if (sel < 70) return 16'($urandom_range(0, 6) - 3);
        if (sel < 85) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        return '0;
    endfunction

    task automatic rand_item(output mix_item_t it);
        int sel;
        sel = $urandom_range(0, 99);
        clock_ms += $urandom_range(0, 40);
        if ($urandom_range(0, 99) < 3) clock_ms = longint'($urandom);
        it.now = 32'(clock_ms);
        it.md = sel < 15 ? MODE_SET : sel < 20 ? MODE_STOP : sel < 50 ? MODE_FB : MODE_TICK;
        it.fwd = rand_cmd();
        it.stf = rand_cmd();
        it.rot = rand_cmd();
        it.idx = $urandom_range(0, 99) < 90 ? 3'($urandom_range(1, 4)) : 3'($urandom);
        it.pres = $urandom_range(0, 99) < 95;
        it.typed = 1'b0;
        it.res = '0;
    endtask

    task automatic run_random(int count);
        mix_item_t it;
        for (int i = 0; i < count; i++)
        begin
            rand_item(it);
            send_item(it);
        end
    endtask

    initial
    begin
        model_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset settings
        add_row(MODE_TICK, 0, 0, 0, 5, 0, 0, 1, 0, 0, 0, 0, 0, 1);
        for (int m = 1; m <= 4; m++) add_row(MODE_FB, 0, 0, 0, 10, m, 1);
        add_row(MODE_SET, 16384, 0, 0, 20, 0, 0);
        add_row(MODE_TICK, 0, 0, 0, 30, 0, 0, 1, 8000, 8000, -8000, -8000, 1, 0);
        add_row(MODE_SET, 0, 0, -32768, 40, 0, 0);
        add_row(MODE_TICK, 0, 0, 0, 50, 0, 0, 1, 6400, 6400, 6400, 6400, 1, 0);
        add_row(MODE_STOP, 0, 0, 0, 60, 0, 0);
        add_row(MODE_TICK, 0, 0, 0, 70, 0, 0, 1, 0, 0, 0, 0, 1, 1);
        add_row(MODE_SET, 5000, 0, 0, 80, 0, 0);
        add_row(MODE_TICK, 0, 0, 0, 90, 0, 0);
        add_row(MODE_TICK, 0, 0, 0, 400, 0, 0, 1, 0, 0, 0, 0, 0, 1);
        for (int m = 1; m <= 4; m++) add_row(MODE_FB, 0, 0, 0, 500, m, 1);
        add_row(MODE_SET, 1, -1, 0, 510, 0, 0);
        add_row(MODE_TICK, 0, 0, 0, 520, 0, 0, 1, 0, 0, 0, 0, 1, 1);
        add_row(MODE_SET, 0, 8000, 3000, 530, 0, 0);
        add_row(MODE_TICK, 0, 0, 0, 700, 0, 0);
        add_row(MODE_TICK, 0, 0, 0, 790, 0, 0);
        add_row(MODE_FB, 0, 0, 0, 795, 0, 0);
        add_row(MODE_FB, 0, 0, 0, 795, 5, 0);
        add_row(MODE_FB, 0, 0, 0, 795, 7, 0);
        add_row(MODE_FB, 0, 0, 0, 800, 2, 0);
        add_row(MODE_TICK, 0, 0, 0, 805, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SET, -16384, 32767, 0, 900, 0, 0);
        add_row(MODE_TICK, 0, 0, 0, 850, 0, 0, 1, 0, 0, 0, 0, 0, 0);
        foreach (dir_rows[i]) send_item(dir_rows[i]);
        clock_ms = 1000;

        // sender idles often, receiver more so
        snd_pct = 33;
        rcv_pct = 83;
        run_random(450);
        wait_idle();

        // random register values, idling swapped
        reg_write(REG_MAX_TR, $urandom_range(0, 16383));
        reg_write(REG_MAX_RO, $urandom_range(0, 16383));
        reg_write(REG_CMD_TO, $urandom_range(50, 2000));
        reg_write(REG_FB_TO, $urandom_range(100, 2000));
        reg_write(REG_BST_SCL, $urandom_range(0, 16384));
        reg_write(REG_BST_MIN, $urandom_range(0, 16384));
        reg_write(REG_BST_DUR, $urandom_range(0, 2000));
        snd_pct = 83;
        rcv_pct = 33;
        run_random(450);
        wait_idle();

        // all-ones registers but a zero boost minimum, no idling, long receiver hold-off
        reg_write(REG_MAX_TR, 16383);
        reg_write(REG_MAX_RO, 16383);
        reg_write(REG_CMD_TO, 65535);
        reg_write(REG_FB_TO, 65535);
        reg_write(REG_BST_SCL, 32767);
        reg_write(REG_BST_MIN, 0);
        reg_write(REG_BST_DUR, 65535);
        snd_pct = 0;
        rcv_pct = 0;
        hold_req++;
        run_random(450);
        wait_idle();

        // zero and small registers, with boost minimum and scale set high
        reg_write(REG_MAX_TR, 0);
        reg_write(REG_MAX_RO, 1);
        reg_write(REG_CMD_TO, 0);
        reg_write(REG_FB_TO, 30);
        reg_write(REG_BST_SCL, 16384);
        reg_write(REG_BST_MIN, 32767);
        reg_write(REG_BST_DUR, 0);
        run_random(225);
        wait_idle();
        reg_write(REG_MAX_TR, 300);
        reg_write(REG_CMD_TO, 400);
        reg_write(REG_FB_TO, 0);
        reg_write(REG_BST_SCL, 0);
        run_random(225);
        wait_idle();

        if (n_err == 0 && exp_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
